// File: rtl/tree_plru_cache_tag_store_defines.svh
// Assertion macros for the tree pseudo-LRU tag store.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef TREE_PLRU_CACHE_TAG_STORE_DEFINES_SVH
`define TREE_PLRU_CACHE_TAG_STORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define TPC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tag store check failed");
// next-cycle implication
`define TPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tag store check failed");
`else
`define TPC_ASSERT_NOW(label, ante, cons)
`define TPC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/tpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tpc_pkg;

    localparam int NUM_WAYS = 4;
    localparam int WAY_W    = 2;
    localparam int TREE_W   = 3;
    localparam int CNT_W    = 16;
    localparam int RES_W    = 1 + WAY_W + TREE_W + CNT_W;
    localparam int OUT_W    = ((RES_W + 7) / 8) * 8;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch address, start row read
        logic commit;    // update set state, load result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_stall; // result register full and not being taken
    } t_sts;

endpackage

`default_nettype wire

// File: rtl/tpc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tpc_ctrl
    import tpc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_tvalid,
    output logic      o_s_tready,
    input  t_sts      i_sts,
    output t_cmd      o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LOOK = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state        = r_state;
        o_s_tready     = 1'b0;
        o_cmd.capture  = 1'b0;
        o_cmd.commit   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.capture = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                // hold until the result register can take the new item
                if (!i_sts.out_stall) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tpc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "tree_plru_cache_tag_store_defines.svh"

module tpc_datapath
    import tpc_pkg::*;
#(
    parameter int ADDR_BITS   = 16,
    parameter int SET_BITS    = 2,
    parameter int OFFSET_BITS = 4
)(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [ADDR_BITS-1:0] i_addr,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [RES_W-1:0]          o_result
);

    localparam int TAG_W    = ADDR_BITS - SET_BITS - OFFSET_BITS;
    localparam int NUM_SETS = 1 << SET_BITS;
    localparam int ROW_W    = NUM_WAYS * TAG_W;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    function automatic logic [WAY_W-1:0] tree_victim(input logic [TREE_W-1:0] t);
        logic [WAY_W-1:0] v;
        if (!t[1]) begin
            v = t[0] ? 2'd1 : 2'd0;
        end else begin
            v = t[2] ? 2'd3 : 2'd2;
        end
        return v;
    endfunction

    // point root and pair bit away from the way just used
    function automatic logic [TREE_W-1:0] tree_touch(input logic [TREE_W-1:0] t,
                                                     input logic [WAY_W-1:0]  w);
        logic [TREE_W-1:0] r;
        r = t;
        case (w)
            2'd0:    begin r[1] = 1'b1; r[0] = 1'b1; end
            2'd1:    begin r[1] = 1'b1; r[0] = 1'b0; end
            2'd2:    begin r[1] = 1'b0; r[2] = 1'b1; end
            default: begin r[1] = 1'b0; r[2] = 1'b0; end
        endcase
        return r;
    endfunction

    logic [ROW_W-1:0]    mem [NUM_SETS];
    logic [ROW_W-1:0]    r_row;
    logic [TAG_W-1:0]    r_tag;
    logic [SET_BITS-1:0] r_set;
    logic [NUM_WAYS-1:0] r_valid [NUM_SETS];
    logic [TREE_W-1:0]   r_tree  [NUM_SETS];
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;

    logic                r_out_valid;
    logic                r_out_hit;
    logic [WAY_W-1:0]    r_out_way;
    logic [TREE_W-1:0]   r_out_tree;
    logic [CNT_W-1:0]    r_out_cnt;

    logic                hit;
    logic [WAY_W-1:0]    way;
    logic [TREE_W-1:0]   n_tree;
    logic [ROW_W-1:0]    n_row;

    // tag memory: one row per set, read on capture, written on commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_row <= mem[i_addr[OFFSET_BITS +: SET_BITS]];
            r_set <= i_addr[OFFSET_BITS +: SET_BITS];
            r_tag <= i_addr[ADDR_BITS-1 -: TAG_W];
        end
        if (i_cmd.commit) begin
            mem[r_set] <= n_row;
        end
    end

    always_comb begin
        hit = 1'b0;
        way = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (!hit && r_valid[r_set][w] && r_row[w*TAG_W +: TAG_W] == r_tag) begin
                hit = 1'b1;
                way = WAY_W'(w);
            end
        end
        if (!hit) begin
            way = tree_victim(r_tree[r_set]);
        end
        n_tree = tree_touch(r_tree[r_set], way);
        n_row  = r_row;
        n_row[way*TAG_W +: TAG_W] = r_tag;
        n_count = r_count;
        if (hit && r_count != CNT_MAX) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SETS; s++) begin
                r_valid[s] <= '0;
                r_tree[s]  <= '0;
            end
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_valid[r_set][way] <= 1'b1;
                r_tree[r_set]       <= n_tree;
                r_count             <= n_count;
                r_out_valid         <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_hit  <= hit;
            r_out_way  <= way;
            r_out_tree <= n_tree;
            r_out_cnt  <= n_count;
        end
    end

    assign o_sts.out_stall = r_out_valid && !i_m_tready;
    assign o_m_tvalid      = r_out_valid;
    assign o_result        = {r_out_cnt, r_out_tree, r_out_way, r_out_hit};

    `TPC_ASSERT_NEXT(a_commit_loads_out, i_cmd.commit, r_out_valid)
    `TPC_ASSERT_NEXT(a_fill_marks_valid, i_cmd.commit && !hit, r_valid[$past(r_set)][$past(way)])
    `TPC_ASSERT_NEXT(a_count_monotone, i_cmd.commit, r_count >= $past(r_count))
    `TPC_ASSERT_NOW(a_root_points_away, r_out_valid, r_out_tree[1] != r_out_way[1])
    `TPC_ASSERT_NOW(a_no_overwrite, i_cmd.commit, !(r_out_valid && !i_m_tready))

endmodule

`default_nettype wire

// File: rtl/tree_plru_cache_tag_store.sv
`timescale 1ns / 1ps
`default_nettype none
// Four-way set-associative tag store with tree pseudo-LRU replacement.
// Input stream (s side): one byte address per item in tdata. The set index
// sits just above the offset bits, the tag is every address bit above it.
// Output stream (m side): one result per input item with hit flag, the way
// that hit or was filled, the set's updated tree bits and a saturating hit
// count.
// An accepted item's set row, set index and tag are registered first; its result
// is loaded into the output register once that register can take it.
// No new item is accepted until the current one is committed; the tag row comes
// from a memory with a registered read port, so each item takes a read step and
// then a compare, victim choice and write-back step.
// A finished result sits in an output register; the next item is accepted
// while it waits, and if the receiver stalls the lookup holds until that
// register is taken.
// Reset (synchronous, active low) clears all valid bits, all tree bits, the
// hit count and the output valid. Tag contents are not cleared; they are
// only read under their valid bits.
module tree_plru_cache_tag_store
    import tpc_pkg::*;
#(
    parameter int ADDR_BITS   = 16,
    parameter int SET_BITS    = 2,
    parameter int OFFSET_BITS = 4
)(
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // address
    input  wire logic [((ADDR_BITS + 7) / 8) * 8-1:0] i_s_tdata,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // hit, way[1:0], tree_bits[2:0], hit_count[15:0], zero pad
    output logic [OUT_W-1:0]                         o_m_tdata
);

    t_cmd             cmd;
    t_sts             sts;
    logic [RES_W-1:0] result;

    tpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tpc_datapath #(
        .ADDR_BITS   (ADDR_BITS),
        .SET_BITS    (SET_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_addr     (i_s_tdata[ADDR_BITS-1:0]),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_result   (result)
    );

    assign o_m_tdata = OUT_W'(result);

endmodule

`default_nettype wire
